@@ design/swcc_pkg.sv @@
// shared widths, register map, reset values and control structs for the change counter
`default_nettype none

package swcc_pkg;

  // payload field widths
  localparam int CODE_W    = 8;
  localparam int TIME_W    = 62;
  localparam int WIN_W     = 40;
  localparam int COUNT_W   = 7;
  localparam int TOTAL_W   = 32;
  localparam int SUM_W     = 48;
  localparam int SAMPLES_W = 40;

  // default fifo depth
  localparam int DEFAULT_DEPTH = 64;

  // configuration port
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 64;
  localparam int REG_SEL_BIT = 3;

  // register indexes
  localparam logic REG_WINDOW   = 1'b0;
  localparam logic REG_DISABLED = 1'b1;

  // register reset values
  localparam logic [WIN_W-1:0]  WINDOW_RESET   = 40'd5000000000;
  localparam logic [CODE_W-1:0] DISABLED_RESET = 8'd1;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

  // controls for the statistics accumulators
  typedef struct packed {
    logic update;
    logic change;
  } stats_ctl_t;

endpackage

`default_nettype wire

@@ design/sliding_window_change_counter_unit.sv @@
// top level of the sliding window change counter: sequencer, config port, cell chain, statistics
//
//   channel   | direction | handshake                 | payload
//   item      | in        | item_valid / item_stall   | indicator_state, timestamp_ns
//   result    | out       | result_valid / result_stall | count_in_window .. window_overflow
//   config    | in        | apb psel / penable        | paddr, pwdata, prdata
//
// an item passes through an expire step and then a finish step: in the expire step the head
// cell of the chain is checked and popped one entry per cycle until it is no longer expired.
// the next item is taken in the cycle its predecessor's beat is written out.
// reset is synchronous and active high; it empties the fifo and clears the stats.
// a stalled result holds the block in its last step until the beat is taken.
`default_nettype none

module sliding_window_change_counter_unit #(
  parameter int WINDOW_DEPTH = swcc_pkg::DEFAULT_DEPTH
) (
  input  wire                              clk,
  input  wire                              rst,
  // configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [swcc_pkg::ADDR_W-1:0]       paddr,
  input  wire [swcc_pkg::DATA_W-1:0]       pwdata,
  output logic [swcc_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  // item channel
  input  wire                              item_valid,
  output logic                             item_stall,
  input  wire [swcc_pkg::CODE_W-1:0]       indicator_state,
  input  wire [swcc_pkg::TIME_W-1:0]       timestamp_ns,
  // result channel
  output logic                             result_valid,
  input  wire                              result_stall,
  output logic [swcc_pkg::COUNT_W-1:0]     count_in_window,
  output logic [swcc_pkg::TOTAL_W-1:0]     total_changes,
  output logic [swcc_pkg::COUNT_W-1:0]     min_count,
  output logic [swcc_pkg::COUNT_W-1:0]     max_count,
  output logic [swcc_pkg::SUM_W-1:0]       count_sum,
  output logic [swcc_pkg::SAMPLES_W-1:0]   sample_count,
  output logic                             window_overflow
);
  import swcc_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH+1);
  localparam int EXT_W = CNT_W + COUNT_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH-1);

  typedef enum logic [1:0] {S_IDLE, S_EXPIRE, S_FINISH} state_t;

  state_t             state;
  logic [WIN_W-1:0]   window_len;
  logic [CODE_W-1:0]  disabled;
  logic [CODE_W-1:0]  prev_code;
  logic [CODE_W-1:0]  code;
  logic [TIME_W-1:0]  now;
  logic [CNT_W-1:0]   occupancy;

  logic [TIME_W-1:0]  cell_time [WINDOW_DEPTH];
  logic [TIME_W-1:0]  diff;
  logic               expired;
  logic               pop_exp;
  logic               slot_free;
  logic               fin;
  logic               change;
  logic               full;
  logic               push;
  logic               ovf;
  logic               accept;
  logic               cfg_wr;
  logic [IDX_W-1:0]   wr_idx;
  logic [CNT_W-1:0]   cnt_fin;
  logic [EXT_W-1:0]   cnt_ext;
  chain_ctl_t         chain_ctl;
  stats_ctl_t         stats_ctl;

  // config port, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
      disabled   <= DISABLED_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[REG_SEL_BIT])
        REG_WINDOW:   window_len <= pwdata[WIN_W-1:0];
        REG_DISABLED: disabled   <= pwdata[CODE_W-1:0];
        default:      window_len <= window_len;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[REG_SEL_BIT])
      REG_WINDOW:   prdata = DATA_W'(window_len);
      REG_DISABLED: prdata = DATA_W'(disabled);
      default:      prdata = '0;
    endcase
  end

  // expiry check on the head cell
  assign diff    = now - cell_time[0];
  assign expired = (now > cell_time[0]) && (diff > TIME_W'(window_len));
  assign pop_exp = (state == S_EXPIRE) && (occupancy != '0) && expired;

  // finishing step and push decision
  assign slot_free = !result_valid || !result_stall;
  assign fin       = (state == S_FINISH) && slot_free;
  assign change    = (code != prev_code) && (code != disabled);
  assign full      = (occupancy == FULL_CNT);
  assign push      = fin && change;
  assign ovf       = push && full;
  assign wr_idx    = full ? LAST_IDX : occupancy[IDX_W-1:0];
  assign cnt_fin   = (push && !full) ? occupancy + CNT_W'(1) : occupancy;
  assign cnt_ext   = EXT_W'(cnt_fin);

  // input handshake
  assign item_stall = !((state == S_IDLE) || fin);
  assign accept     = item_valid && !item_stall;

  // chain and stats controls
  assign chain_ctl.shift  = pop_exp || ovf;
  assign chain_ctl.load   = push;
  assign stats_ctl.update = fin;
  assign stats_ctl.change = change;

  // sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prev_code    <= '0;
      occupancy    <= '0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXPIRE;
          end
        end
        S_EXPIRE: begin
          if (!pop_exp) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (fin) begin
            state <= accept ? S_EXPIRE : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (pop_exp) begin
        occupancy <= occupancy - CNT_W'(1);
      end else if (push && !full) begin
        occupancy <= occupancy + CNT_W'(1);
      end
      if (fin) begin
        prev_code <= code;
      end
      result_valid <= fin || (result_valid && result_stall);
    end
    // payload, no reset
    if (accept) begin
      code <= indicator_state;
      now  <= timestamp_ns;
    end
    if (fin) begin
      count_in_window <= cnt_ext[COUNT_W-1:0];
      window_overflow <= ovf;
    end
  end

  // chain of change-time cells, head at index zero
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == WINDOW_DEPTH - 1) begin : g_last
      swcc_cell #(
        .IDX_W (IDX_W),
        .IDX   (i)
      ) u_cell (
        .clk           (clk),
        .ctl           (chain_ctl),
        .wr_idx        (wr_idx),
        .load_time     (now),
        .neighbor_time (cell_time[i]),
        .cell_time     (cell_time[i])
      );
    end else begin : g_mid
      swcc_cell #(
        .IDX_W (IDX_W),
        .IDX   (i)
      ) u_cell (
        .clk           (clk),
        .ctl           (chain_ctl),
        .wr_idx        (wr_idx),
        .load_time     (now),
        .neighbor_time (cell_time[i+1]),
        .cell_time     (cell_time[i])
      );
    end
  end

  // statistics
  swcc_stats #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_stats (
    .clk           (clk),
    .rst           (rst),
    .ctl           (stats_ctl),
    .cnt           (cnt_fin),
    .total_changes (total_changes),
    .min_count     (min_count),
    .max_count     (max_count),
    .count_sum     (count_sum),
    .sample_count  (sample_count)
  );

endmodule

`default_nettype wire

@@ design/swcc_cell.sv @@
// one entry of the change-time chain: loads a new time or takes its neighbor's on a shift
`default_nettype none

module swcc_cell #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  wire                           clk,
  input  swcc_pkg::chain_ctl_t          ctl,
  input  wire [IDX_W-1:0]               wr_idx,
  input  wire [swcc_pkg::TIME_W-1:0]    load_time,
  input  wire [swcc_pkg::TIME_W-1:0]    neighbor_time,
  output logic [swcc_pkg::TIME_W-1:0]   cell_time
);
  import swcc_pkg::*;

  logic sel;

  // this cell is the write slot
  assign sel = ctl.load && (wr_idx == IDX_W'(IDX));

  // entry register, no reset on payload
  always_ff @(posedge clk) begin
    if (sel) begin
      cell_time <= load_time;
    end else if (ctl.shift) begin
      cell_time <= neighbor_time;
    end
  end

endmodule

`default_nettype wire

@@ design/swcc_stats.sv @@
// running total, minimum, maximum, sum and sample count of the in-window count
`default_nettype none

module swcc_stats #(
  parameter int WINDOW_DEPTH = swcc_pkg::DEFAULT_DEPTH
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  swcc_pkg::stats_ctl_t                ctl,
  input  wire [$clog2(WINDOW_DEPTH+1)-1:0]    cnt,
  output logic [swcc_pkg::TOTAL_W-1:0]        total_changes,
  output logic [swcc_pkg::COUNT_W-1:0]        min_count,
  output logic [swcc_pkg::COUNT_W-1:0]        max_count,
  output logic [swcc_pkg::SUM_W-1:0]          count_sum,
  output logic [swcc_pkg::SAMPLES_W-1:0]      sample_count
);
  import swcc_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH+1);
  localparam int EXT_W = CNT_W + COUNT_W;

  logic [CNT_W-1:0]     min_reg;
  logic [CNT_W-1:0]     max_reg;
  logic [SUM_W:0]       sum_wide;
  logic [EXT_W-1:0]     min_ext;
  logic [EXT_W-1:0]     max_ext;

  // saturating sum with carry out
  assign sum_wide = {1'b0, count_sum} + (SUM_W+1)'(cnt);

  // counts wider than the port are masked
  assign min_ext   = EXT_W'(min_reg);
  assign max_ext   = EXT_W'(max_reg);
  assign min_count = min_ext[COUNT_W-1:0];
  assign max_count = max_ext[COUNT_W-1:0];

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      total_changes <= '0;
      min_reg       <= '1;
      max_reg       <= '0;
      count_sum     <= '0;
      sample_count  <= '0;
    end else if (ctl.update) begin
      if (ctl.change && (total_changes != '1)) begin
        total_changes <= total_changes + TOTAL_W'(1);
      end
      if ((sample_count == '0) || (cnt < min_reg)) begin
        min_reg <= cnt;
      end
      if (cnt > max_reg) begin
        max_reg <= cnt;
      end
      if (sum_wide[SUM_W]) begin
        count_sum <= '1;
      end else begin
        count_sum <= sum_wide[SUM_W-1:0];
      end
      if (sample_count != '1) begin
        sample_count <= sample_count + SAMPLES_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
